// File: sv/pid_rl_pkg.sv
// Shared types and constants for the rate-limited PID controller.
// Depends on nothing; every other file of the block imports it.
package pid_rl_pkg;

  // Q16.16 data and the widths that follow from it.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = DATA_W + DIFF_W;
  localparam int unsigned TERM_W    = PROD_W - FRAC_W;
  localparam int unsigned ACC_W     = TERM_W + 2;
  localparam int unsigned SLEW_W    = 31;
  localparam int unsigned SLW_W     = DATA_W + 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values.
  localparam logic signed [DATA_W-1:0] DRIVE_MAX_RST = 32'sd6553600;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN_RST = -32'sd6553600;
  localparam logic [SLEW_W-1:0]        SLEW_RST      = 31'd65536;

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_INIT    = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_TARGET     = 3'd3,
    CFG_P_ON_ERROR = 3'd4,
    CFG_DRIVE_MAX  = 3'd5,
    CFG_DRIVE_MIN  = 3'd6,
    CFG_SLEW_LIMIT = 3'd7
  } cfg_idx_e;

  // Current register contents.
  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] target;
    logic                     p_on_error;
    logic signed [DATA_W-1:0] drive_max;
    logic signed [DATA_W-1:0] drive_min;
    logic [SLEW_W-1:0]        slew_limit;
  } cfg_t;

  // One registered input request.
  typedef struct packed {
    opcode_e                  op;
    logic signed [DATA_W-1:0] meas;
    logic signed [DATA_W-1:0] init_drive;
  } item_t;

  // Scaled terms handed from the multiply stage to the output stage.
  typedef struct packed {
    opcode_e                  op;
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
    logic signed [DATA_W-1:0] init_drive;
  } prod_t;

endpackage

// File: sv/pid_rl_if.sv
// Valid/ready channel interfaces of the rate-limited PID controller.
// Depends on pid_rl_pkg for the field widths.
interface pid_rl_item_if import pid_rl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] measurement;
  logic signed [DATA_W-1:0] init_drive;

  modport source(output valid, opcode, measurement, init_drive, input ready);
  modport sink(input valid, opcode, measurement, init_drive, output ready);
endinterface

interface pid_rl_result_if import pid_rl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source(output valid, drive, input ready);
  modport sink(input valid, drive, output ready);
endinterface

interface pid_rl_cfg_if import pid_rl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/pid_rl_cfg.sv
// Configuration register file of the rate-limited PID controller.
// Depends on pid_rl_pkg and the pid_rl_cfg_if interface.
module pid_rl_cfg import pid_rl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pid_rl_cfg_if.sink  cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; each request updates one register.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_GAIN_P:     cfg_d.gain_p     = $signed(cfg_i.data);
        CFG_GAIN_I:     cfg_d.gain_i     = $signed(cfg_i.data);
        CFG_GAIN_D:     cfg_d.gain_d     = $signed(cfg_i.data);
        CFG_TARGET:     cfg_d.target     = $signed(cfg_i.data);
        CFG_P_ON_ERROR: cfg_d.p_on_error = cfg_i.data[0];
        CFG_DRIVE_MAX:  cfg_d.drive_max  = $signed(cfg_i.data);
        CFG_DRIVE_MIN:  cfg_d.drive_min  = $signed(cfg_i.data);
        CFG_SLEW_LIMIT: cfg_d.slew_limit = cfg_i.data[SLEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.target     <= '0;
      cfg_q.p_on_error <= 1'b1;
      cfg_q.drive_max  <= DRIVE_MAX_RST;
      cfg_q.drive_min  <= DRIVE_MIN_RST;
      cfg_q.slew_limit <= SLEW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/pid_rl_mul.sv
// Multiply stage: error and measurement differences, three gain products,
// scaling by 2^-16. Depends on pid_rl_pkg.
module pid_rl_mul import pid_rl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  adv_i,
  output logic  prod_valid_o,
  output prod_t prod_o
);

  logic                     prod_valid_q;
  prod_t                    prod_q, prod_d;
  logic signed [DATA_W-1:0] prev_meas_q;
  logic signed [DATA_W-1:0] start_meas_q;
  logic                     take;

  logic signed [DIFF_W-1:0] err;
  logic signed [DIFF_W-1:0] dmeas;
  logic signed [DIFF_W-1:0] dstart;
  logic signed [DIFF_W-1:0] p_diff;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] i_prod;
  logic signed [PROD_W-1:0] d_prod;
  logic signed [PROD_W-1:0] p_sel;
  logic signed [PROD_W-1:0] d_neg;

  // The stage takes a request when it is empty or its item moves on.
  assign ready_o = !prod_valid_q || adv_i;
  assign take    = ready_o && item_valid_i;

  // Differences are formed one bit wider so nothing wraps.
  assign err    = DIFF_W'(cfg_i.target) - DIFF_W'(item_i.meas);
  assign dmeas  = DIFF_W'(item_i.meas) - DIFF_W'(prev_meas_q);
  assign dstart = DIFF_W'(item_i.meas) - DIFF_W'(start_meas_q);
  assign p_diff = cfg_i.p_on_error ? err : dstart;

  // Exact products; the negated terms are negated before the shift.
  assign p_prod = cfg_i.gain_p * p_diff;
  assign i_prod = cfg_i.gain_i * err;
  assign d_prod = cfg_i.gain_d * dmeas;
  assign p_sel  = cfg_i.p_on_error ? p_prod : -p_prod;
  assign d_neg  = -d_prod;

  always_comb begin
    prod_d.op         = item_i.op;
    prod_d.p_term     = p_sel[PROD_W-1:FRAC_W];
    prod_d.i_term     = i_prod[PROD_W-1:FRAC_W];
    prod_d.d_term     = d_neg[PROD_W-1:FRAC_W];
    prod_d.init_drive = item_i.init_drive;
  end

  // Measurement history advances in request order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      prev_meas_q  <= '0;
      start_meas_q <= '0;
    end else begin
      if (ready_o) begin
        prod_valid_q <= item_valid_i;
      end
      if (take) begin
        prev_meas_q <= item_i.meas;
        if (item_i.op == OP_INIT) begin
          start_meas_q <= item_i.meas;
        end
      end
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_valid_q;
  assign prod_o       = prod_q;

endmodule

// File: sv/pid_rl_out.sv
// Output stage: integral with anti-windup, sum, clamp, slew limit and
// the result register. Depends on pid_rl_pkg and pid_rl_result_if.
module pid_rl_out import pid_rl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              prod_valid_i,
  input  prod_t             prod_i,
  output logic              adv_o,
  pid_rl_result_if.source   result_o
);

  logic signed [DATA_W-1:0] integral_q, integral_d;
  logic signed [DATA_W-1:0] prev_drive_q, prev_drive_d;
  logic signed [DATA_W-1:0] drive_q, drive_d;
  logic                     out_valid_q, out_valid_d;
  logic                     upd;
  logic                     is_compute;

  logic signed [ACC_W-1:0]  int_acc;
  logic signed [DATA_W-1:0] int_new;
  logic signed [ACC_W-1:0]  total;
  logic signed [DATA_W-1:0] sum_c;
  logic signed [SLW_W-1:0]  slew_s;
  logic signed [SLW_W-1:0]  slew_lo;
  logic signed [SLW_W-1:0]  slew_hi;
  logic signed [SLW_W-1:0]  s_low;
  logic signed [SLW_W-1:0]  s_fin;

  // Upper limit first: inverted limits give max above it, else min.
  function automatic logic signed [DATA_W-1:0] clamp_lim(
    input logic signed [ACC_W-1:0]  v,
    input logic signed [DATA_W-1:0] hi,
    input logic signed [DATA_W-1:0] lo
  );
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(hi)) begin
      r = hi;
    end else if (v < ACC_W'(lo)) begin
      r = lo;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // The stage moves when the result register is free or being emptied.
  assign adv_o      = !out_valid_q || result_o.ready;
  assign upd        = prod_valid_i && adv_o;
  assign is_compute = (prod_i.op == OP_COMPUTE);

  // Integral and clamped sum.
  assign int_acc = ACC_W'(integral_q) + ACC_W'(prod_i.i_term);
  assign int_new = clamp_lim(int_acc, cfg_i.drive_max, cfg_i.drive_min);
  assign total   = ACC_W'(prod_i.p_term) + ACC_W'(prod_i.d_term) + ACC_W'(int_new);
  assign sum_c   = clamp_lim(total, cfg_i.drive_max, cfg_i.drive_min);

  // Slew limit around the last drive: lower bound first, then upper.
  assign slew_s  = $signed({{(SLW_W-SLEW_W){1'b0}}, cfg_i.slew_limit});
  assign slew_lo = SLW_W'(prev_drive_q) - slew_s;
  assign slew_hi = SLW_W'(prev_drive_q) + slew_s;
  assign s_low   = (SLW_W'(sum_c) < slew_lo) ? slew_lo : SLW_W'(sum_c);
  assign s_fin   = (s_low > slew_hi) ? slew_hi : s_low;
  assign drive_d = s_fin[DATA_W-1:0];

  // State updates for a compute or an init request.
  always_comb begin
    if (is_compute) begin
      integral_d   = int_new;
      prev_drive_d = drive_d;
    end else begin
      integral_d   = clamp_lim(ACC_W'(prod_i.init_drive), cfg_i.drive_max, cfg_i.drive_min);
      prev_drive_d = prod_i.init_drive;
    end
  end

  // Only compute requests leave a result.
  assign out_valid_d = upd ? is_compute : (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q   <= '0;
      prev_drive_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (upd) begin
        integral_q   <= integral_d;
        prev_drive_q <= prev_drive_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd && is_compute) begin
      drive_q <= drive_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.drive = drive_q;

  // A delivered drive becomes the reference for the next slew limit.
  a_drive_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && is_compute |=> prev_drive_q == drive_q)
    else $error("last drive differs from the presented result");

  // With ordered limits the integral stays inside them after any update.
  a_integral_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && (cfg_i.drive_max >= cfg_i.drive_min)
    |=> (integral_q <= cfg_i.drive_max) && (integral_q >= cfg_i.drive_min))
    else $error("integral escaped the drive limits");

  // A stalled result freezes the controller state.
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready
    |=> out_valid_q && $stable(prev_drive_q) && $stable(integral_q))
    else $error("controller state moved while the result was stalled");

endmodule

// File: sv/pid_rl_ctrl_top.sv
// Top level of the rate-limited PID controller: input register and stage glue.
// Depends on pid_rl_pkg, the pid_rl interfaces, pid_rl_cfg, pid_rl_mul, pid_rl_out.

// File: sv/pid_rate_limited_controller.sv
// Rate-limited PID controller, signed Q16.16. One request is accepted per clock
// cycle unless a result stall holds the stages; a compute request (opcode 0) passes
// the input register, the multiply register and the result register before its
// drive shows on the result channel. An init request (opcode 1) loads the
// controller state and gives no result. The rate is set by the output stage, which
// closes the integral and last-drive feedback as it takes each request, so it can
// take a new one as soon as the result register is free or being emptied. Stalls on
// the result side back up through the stages; empty stages keep taking requests.
// Configuration writes are taken every cycle and must only be issued while no
// request is in flight. There is no clearing pass after reset.
module pid_rate_limited_controller import pid_rl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  pid_rl_item_if.sink     item_i,
  pid_rl_result_if.source result_o,
  pid_rl_cfg_if.sink      cfg_i
);

  cfg_t  cfg;
  logic  item_valid_q;
  item_t item_q;
  logic  mul_ready;
  logic  prod_valid;
  prod_t prod;
  logic  adv;
  logic  accept;

  // Input register: free when empty or when its request moves on.
  assign item_i.ready = !item_valid_q || mul_ready;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      item_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op         <= opcode_e'(item_i.opcode);
      item_q.meas       <= item_i.measurement;
      item_q.init_drive <= item_i.init_drive;
    end
  end

  pid_rl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pid_rl_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .ready_o      (mul_ready),
    .adv_i        (adv),
    .prod_valid_o (prod_valid),
    .prod_o       (prod)
  );

  pid_rl_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .adv_o        (adv),
    .result_o     (result_o)
  );

endmodule

// File: tb/pid_rate_limited_controller_test.sv
// Self-checking test of the rate-limited PID controller: directed corner requests,
// then randomized phases of settings and request streams. Depends on pid_rl_pkg,
// the channel interfaces in pid_rl_if.sv and the controller top level.
module pid_rate_limited_controller_test;
  import pid_rl_pkg::*;

  localparam int unsigned HALF_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_REQUESTS = 117;
  localparam int unsigned MAX_REPORTS    = 20;
  localparam int          ONE_Q          = 65536;
  localparam logic signed [DATA_W-1:0] S32_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN  = 32'sh8000_0000;
  localparam logic [DATA_W-1:0]        SLEW_TOP = 32'h7fff_ffff;

  // Wide enough that no product or sum of the controller can overflow.
  typedef logic signed [DATA_W+64-1:0] wide_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  pid_rl_item_if   item_if ();
  pid_rl_result_if result_if ();
  pid_rl_cfg_if    cfg_if ();

  pid_rate_limited_controller i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // Predicted controller settings and state.
  cfg_t                     regs;
  logic signed [DATA_W-1:0] integ_acc;
  logic signed [DATA_W-1:0] last_meas;
  logic signed [DATA_W-1:0] last_drive;
  logic signed [DATA_W-1:0] start_meas;

  // Drives predicted for accepted compute requests, oldest first.
  logic signed [DATA_W-1:0] drive_due_q[$];
  logic signed [DATA_W-1:0] expected_drive;

  int unsigned mismatches  = 0;
  int unsigned reports     = 0;
  int unsigned n_compute   = 0;
  int unsigned n_init      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_writes    = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          steady      = 1'b0;

  function automatic wide_t widen(input logic signed [DATA_W-1:0] v);
    return v;
  endfunction

  // Q16.16 product back to Q16.16, rounding toward minus infinity.
  function automatic wide_t scale(input wide_t prod);
    return prod >>> FRAC_W;
  endfunction

  // The upper limit is tested first, which matters when the limits are inverted.
  function automatic wide_t within_limits(input wide_t v);
    if (v > widen(regs.drive_max)) return widen(regs.drive_max);
    if (v < widen(regs.drive_min)) return widen(regs.drive_min);
    return v;
  endfunction

  // Advances the predicted controller by one request and gives its drive, if any.
  function automatic void step_controller(input opcode_e op,
                                          input logic signed [DATA_W-1:0] meas,
                                          input logic signed [DATA_W-1:0] init_drv,
                                          output bit has_drive,
                                          output logic signed [DATA_W-1:0] drive);
    wide_t err;
    wide_t p_term;
    wide_t d_term;
    wide_t total;
    wide_t slew;
    has_drive = 1'b0;
    drive     = '0;
    if (op == OP_INIT) begin
      last_meas  = meas;
      start_meas = meas;
      last_drive = init_drv;
      total      = within_limits(widen(init_drv));
      integ_acc  = total[DATA_W-1:0];
      return;
    end
    err       = widen(regs.target) - widen(meas);
    total     = within_limits(widen(integ_acc) + scale(widen(regs.gain_i) * err));
    integ_acc = total[DATA_W-1:0];
    if (regs.p_on_error) begin
      p_term = scale(widen(regs.gain_p) * err);
    end else begin
      p_term = scale(-(widen(regs.gain_p) * (widen(meas) - widen(start_meas))));
    end
    d_term = scale(-(widen(regs.gain_d) * (widen(meas) - widen(last_meas))));
    total  = within_limits(p_term + d_term + widen(integ_acc));
    // Slew limit: lower bound first, then upper bound.
    slew = '0;
    slew[SLEW_W-1:0] = regs.slew_limit;
    if (total < widen(last_drive) - slew) total = widen(last_drive) - slew;
    if (total > widen(last_drive) + slew) total = widen(last_drive) + slew;
    last_meas  = meas;
    last_drive = total[DATA_W-1:0];
    has_drive  = 1'b1;
    drive      = total[DATA_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones, none during steady stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Writes one register and mirrors it in the predicted settings.
  task automatic write_register(input cfg_idx_e idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_GAIN_P:     regs.gain_p     = data;
      CFG_GAIN_I:     regs.gain_i     = data;
      CFG_GAIN_D:     regs.gain_d     = data;
      CFG_TARGET:     regs.target     = data;
      CFG_P_ON_ERROR: regs.p_on_error = data[0];
      CFG_DRIVE_MAX:  regs.drive_max  = data;
      CFG_DRIVE_MIN:  regs.drive_min  = data;
      CFG_SLEW_LIMIT: regs.slew_limit = data[SLEW_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic write_all(input logic signed [DATA_W-1:0] gp, input logic signed [DATA_W-1:0] gi,
                           input logic signed [DATA_W-1:0] gd, input logic signed [DATA_W-1:0] tgt,
                           input logic [DATA_W-1:0] poe_word,
                           input logic signed [DATA_W-1:0] dmax,
                           input logic signed [DATA_W-1:0] dmin,
                           input logic [DATA_W-1:0] slew_word);
    write_register(CFG_GAIN_P, gp);
    write_register(CFG_GAIN_I, gi);
    write_register(CFG_GAIN_D, gd);
    write_register(CFG_TARGET, tgt);
    write_register(CFG_P_ON_ERROR, poe_word);
    write_register(CFG_DRIVE_MAX, dmax);
    write_register(CFG_DRIVE_MIN, dmin);
    write_register(CFG_SLEW_LIMIT, slew_word);
  endtask

  // Sends one request after a random gap and records its predicted drive.
  task automatic send_request(input opcode_e op, input logic signed [DATA_W-1:0] meas,
                              input logic signed [DATA_W-1:0] init_drv);
    int unsigned              gap;
    bit                       has_drive;
    logic signed [DATA_W-1:0] drive;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      item_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid       = 1'b1;
    item_if.opcode      = op;
    item_if.measurement = meas;
    item_if.init_drive  = init_drv;
    do @(posedge clk_i); while (!item_if.ready);
    step_controller(op, meas, init_drv, has_drive, drive);
    if (has_drive) begin
      drive_due_q.push_back(drive);
      n_compute++;
    end else begin
      n_init++;
    end
  endtask

  // Holds requests back until every drive has come and init requests have drained.
  task automatic wait_for_quiet();
    @(negedge clk_i);
    item_if.valid = 1'b0;
    while (drive_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // With settings at reset the gains are zero, so the drive must stay at zero.
  task automatic test_reset_defaults();
    send_request(OP_COMPUTE, 0, 0);
    send_request(OP_COMPUTE, S32_MAX, S32_MIN);
  endtask

  task automatic test_field_extremes();
    wait_for_quiet();
    write_all(S32_MAX, S32_MIN, S32_MAX, S32_MIN, 1, S32_MAX, S32_MIN, SLEW_TOP);
    send_request(OP_INIT, S32_MAX, S32_MIN);
    send_request(OP_COMPUTE, S32_MIN, 0);
    send_request(OP_COMPUTE, S32_MAX, S32_MAX);
    send_request(OP_INIT, S32_MIN, S32_MAX);
    send_request(OP_COMPUTE, S32_MAX, 0);
    send_request(OP_COMPUTE, 0, 0);
  endtask

  // Proportional on measurement, with the most negative gain against full swings.
  task automatic test_p_on_measurement();
    wait_for_quiet();
    write_all(S32_MIN, ONE_Q / 4, S32_MIN, 5 * ONE_Q, 0, S32_MAX, S32_MIN, SLEW_TOP);
    send_request(OP_INIT, S32_MIN, 0);
    send_request(OP_COMPUTE, S32_MAX, 0);
    send_request(OP_COMPUTE, 5 * ONE_Q, 0);
    send_request(OP_COMPUTE, -3 * ONE_Q, 0);
  endtask

  // Lower limit above the upper one: clamps resolve toward the upper limit first.
  task automatic test_inverted_limits();
    wait_for_quiet();
    write_all(2 * ONE_Q, ONE_Q / 2, ONE_Q, 5 * ONE_Q, 1, -10 * ONE_Q, 10 * ONE_Q, 50 * ONE_Q);
    send_request(OP_INIT, 0, 0);
    send_request(OP_COMPUTE, 0, 0);
    send_request(OP_COMPUTE, 20 * ONE_Q, 0);
    send_request(OP_COMPUTE, -20 * ONE_Q, 0);
  endtask

  // A zero slew limit freezes the drive; a small one lets it creep.
  task automatic test_zero_slew();
    wait_for_quiet();
    write_all(ONE_Q, ONE_Q, 0, 10 * ONE_Q, 1, 100 * ONE_Q, -100 * ONE_Q, 0);
    send_request(OP_INIT, 0, 3 * ONE_Q);
    send_request(OP_COMPUTE, 0, 0);
    send_request(OP_COMPUTE, -50 * ONE_Q, 0);
    wait_for_quiet();
    write_register(CFG_SLEW_LIMIT, ONE_Q / 4);
    send_request(OP_COMPUTE, 0, 0);
  endtask

  // Each phase picks new settings, starts with an init request and then runs a
  // measurement walk around zero, with full-range noise and re-inits mixed in.
  task automatic test_random_phases();
    int unsigned              phase;
    int unsigned              k;
    int                       walk;
    bit                       wild;
    logic signed [DATA_W-1:0] gp, gi, gd, tgt, dmax, dmin, meas, drv;
    logic [DATA_W-1:0]        slew_word;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_quiet();
      steady = (phase == 2) || (phase == 5);
      wild   = (phase % 4) == 3;
      if (wild) begin
        gp   = $urandom();
        gi   = $urandom();
        gd   = $urandom();
        tgt  = $urandom();
        dmax = $urandom();
        dmin = $urandom();
      end else begin
        gp   = int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
        gi   = int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
        gd   = int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
        tgt  = int'($urandom_range(0, 100 * ONE_Q)) - 50 * ONE_Q;
        dmax = int'($urandom_range(0, 200 * ONE_Q));
        dmin = -int'($urandom_range(0, 200 * ONE_Q));
      end
      if (phase == 5) begin
        drv  = dmax;
        dmax = dmin;
        dmin = drv;
      end
      if (phase == 1) slew_word = 0;
      else if (phase == 4) slew_word = SLEW_TOP;
      else if (wild) slew_word = $urandom();
      else slew_word = $urandom_range(0, 20 * ONE_Q);
      write_all(gp, gi, gd, tgt, $urandom(), dmax, dmin, slew_word);

      walk = int'($urandom_range(0, 40 * ONE_Q)) - 20 * ONE_Q;
      send_request(OP_INIT, walk, int'($urandom_range(0, 400 * ONE_Q)) - 200 * ONE_Q);
      for (k = 1; k < PHASE_REQUESTS; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          meas = wild ? $urandom() : walk;
          drv  = ($urandom_range(0, 3) == 0) ? $urandom()
                 : int'($urandom_range(0, 400 * ONE_Q)) - 200 * ONE_Q;
          send_request(OP_INIT, meas, drv);
        end else begin
          meas = (wild || $urandom_range(0, 9) == 0) ? $urandom() : walk;
          send_request(OP_COMPUTE, meas, $urandom());
        end
        walk += int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
        if (walk > 100 * ONE_Q || walk < -100 * ONE_Q) walk = 0;
      end
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls on ready, changed at the falling edge.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      result_if.ready = 1'b0;
      stall_left--;
    end else begin
      result_if.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Every accepted drive is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) begin
      n_checked++;
      if (drive_due_q.size() == 0) begin
        mismatches++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: drive %0d arrived with no request pending, expected none",
                   $time, result_if.drive);
        end
      end else begin
        expected_drive = drive_due_q.pop_front();
        if (result_if.drive !== expected_drive) begin
          mismatches++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: drive mismatch, expected %0d, actual %0d",
                     $time, expected_drive, result_if.drive);
          end
        end
      end
    end
  end

  // Watchdog: too long without any request, result or register write ends the run.
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d drives outstanding",
               $time, idle_cycles, drive_due_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    item_if.valid       = 1'b0;
    item_if.opcode      = OP_COMPUTE;
    item_if.measurement = '0;
    item_if.init_drive  = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_GAIN_P;
    cfg_if.data         = '0;
    result_if.ready     = 1'b0;

    // Settings and state as they come out of reset.
    regs.gain_p     = '0;
    regs.gain_i     = '0;
    regs.gain_d     = '0;
    regs.target     = '0;
    regs.p_on_error = 1'b1;
    regs.drive_max  = DRIVE_MAX_RST;
    regs.drive_min  = DRIVE_MIN_RST;
    regs.slew_limit = SLEW_RST;
    integ_acc       = '0;
    last_meas       = '0;
    last_drive      = '0;
    start_meas      = '0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_p_on_measurement();
    test_inverted_limits();
    test_zero_slew();
    test_random_phases();
    wait_for_quiet();

    $display("Ran %0d compute and %0d init requests with %0d register writes; %0d drives checked.",
             n_compute, n_init, n_writes, n_checked);
    $display("Settings spanned full-range gains, inverted limits, zero and widest slew, both P modes.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d drive errors", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
